### hdl/brfu_pkg.sv
package brfu_pkg;

   localparam int MAX_SLOTS = 256;
   localparam int PTR_BITS = $clog2(MAX_SLOTS);
   localparam int SIZE_BITS = 9;
   localparam int FILL_BITS = 8;
   localparam int COUNT_BITS = 16;
   localparam int DATA_BITS = 8;
   localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(MAX_SLOTS);

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_DELETE = 2'd2,
      OP_FLUSH  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_REFUSED = 2'd1,
      ST_CORRUPT = 2'd2
   } status_type;

   typedef struct packed {
      logic                 wr_en;
      logic                 rd_en;
      logic [PTR_BITS-1:0]  wr_addr;
      logic [PTR_BITS-1:0]  rd_addr;
      logic [DATA_BITS-1:0] wr_data;
   } mem_req_type;

   typedef struct packed {
      status_type            status;
      logic                  pop_ok;
      logic [FILL_BITS-1:0]  fill_level;
      logic [COUNT_BITS-1:0] overflow_count;
   } result_type;

endpackage

### hdl/brfu_ram.sv
module brfu_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/brfu_ctrl.sv
module brfu_ctrl
   import brfu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  opcode_type            opcode,
   input  logic [DATA_BITS-1:0]  data_in,
   input  logic                  csr_wr_en,
   input  logic [SIZE_BITS-1:0]  csr_wr_data,
   output mem_req_type           mem_req,
   output result_type            result
);

   logic [PTR_BITS-1:0]   wp_ff, wp_in;
   logic [PTR_BITS-1:0]   rp_ff, rp_in;
   logic [FILL_BITS-1:0]  held_ff, held_in;
   logic [COUNT_BITS-1:0] refused_ff, refused_in;
   logic [SIZE_BITS-1:0]  size_ff, size_in;

   logic [SIZE_BITS-1:0]  eff_size;
   logic [SIZE_BITS-1:0]  wp_inc;
   logic [SIZE_BITS-1:0]  rp_inc;
   logic [SIZE_BITS-1:0]  size_dec;
   logic [PTR_BITS-1:0]   wp_next;
   logic [PTR_BITS-1:0]   rp_next;
   logic [PTR_BITS-1:0]   wp_prev;
   logic [COUNT_BITS-1:0] refused_sat;
   logic                  corrupt;

   assign eff_size = (size_ff > SIZE_RESET) ? SIZE_RESET : size_ff;
   assign corrupt = ({1'b0, wp_ff} >= eff_size) || ({1'b0, rp_ff} >= eff_size);
   assign wp_inc = {1'b0, wp_ff} + SIZE_BITS'(1);
   assign rp_inc = {1'b0, rp_ff} + SIZE_BITS'(1);
   assign size_dec = eff_size - SIZE_BITS'(1);
   assign wp_next = (wp_inc >= eff_size) ? '0 : wp_inc[PTR_BITS-1:0];
   assign rp_next = (rp_inc >= eff_size) ? '0 : rp_inc[PTR_BITS-1:0];
   assign wp_prev = (wp_ff != '0) ? wp_ff - PTR_BITS'(1) : size_dec[PTR_BITS-1:0];
   assign refused_sat = (&refused_ff) ? refused_ff : refused_ff + COUNT_BITS'(1);
   assign size_in = csr_wr_en ? csr_wr_data : size_ff;

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      held_in = held_ff;
      refused_in = refused_ff;
      result.status = ST_DONE;
      result.pop_ok = 1'b0;
      mem_req.wr_en = 1'b0;
      mem_req.rd_en = 1'b0;
      mem_req.wr_addr = wp_ff;
      mem_req.rd_addr = rp_ff;
      mem_req.wr_data = data_in;
      if (!accept) begin
      end else if (opcode == OP_FLUSH) begin
         wp_in = '0;
         rp_in = '0;
         held_in = '0;
         refused_in = '0;
      end else if (corrupt) begin
         result.status = ST_CORRUPT;
      end else begin
         unique case (opcode)
            OP_PUSH: begin
               if (wp_next != rp_ff) begin
                  mem_req.wr_en = 1'b1;
                  wp_in = wp_next;
                  held_in = held_ff + FILL_BITS'(1);
               end else begin
                  refused_in = refused_sat;
                  result.status = ST_REFUSED;
               end
            end
            OP_POP: begin
               if (rp_ff != wp_ff) begin
                  mem_req.rd_en = 1'b1;
                  result.pop_ok = 1'b1;
                  rp_in = rp_next;
                  held_in = held_ff - FILL_BITS'(1);
               end else begin
                  wp_in = '0;
                  rp_in = '0;
                  held_in = '0;
                  result.status = ST_REFUSED;
               end
               refused_in = '0;
            end
            OP_DELETE: begin
               if (wp_ff != rp_ff) begin
                  wp_in = wp_prev;
                  held_in = held_ff - FILL_BITS'(1);
               end else begin
                  result.status = ST_REFUSED;
               end
               refused_in = '0;
            end
            default: begin
            end
         endcase
      end
      result.fill_level = held_in;
      result.overflow_count = refused_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         held_ff <= '0;
         refused_ff <= '0;
         size_ff <= SIZE_RESET;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         held_ff <= held_in;
         refused_ff <= refused_in;
         size_ff <= size_in;
      end
   end

`ifndef SYNTHESIS
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      accept && opcode == OP_FLUSH |=>
         wp_ff == '0 && rp_ff == '0 && held_ff == '0 && refused_ff == '0)
      else $error("flush did not clear the ring state");

   a_one_port_op: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.wr_en && mem_req.rd_en))
      else $error("memory read and write issued for the same transfer");

   a_refused_step: assert property (@(posedge clock) disable iff (reset)
      refused_ff != $past(refused_ff) |->
         refused_ff == '0 || refused_ff == $past(refused_ff) + COUNT_BITS'(1))
      else $error("refused counter moved by more than one");
`endif

endmodule

### hdl/byte_ring_fifo_with_undo_core.sv
// Channel  Ports     Direction  Contents
// req      req_t*    in         tuser: opcode; tdata: data_in
// rsp      rsp_t*    out        tuser: status; tdata: data_out, fill_level, overflow_count
// csr      csr_wr_*  in         ring_size, written when csr_wr_en is high
//
// Pointers update at the transfer and the byte memory is read at the same edge, so its
// registered read port holds the popped byte for the result.
// One operation per cycle is sustained while the result side keeps taking transfers.
// Reset clears the pointers, counters and result valid and sets the ring size to 256.
// A stalled result blocks new requests; the byte memory keeps undefined contents.
module byte_ring_fifo_with_undo_core
   import brfu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_in
   input  logic [1:0]            req_tuser,   // [1:0] opcode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // [7:0] data_out, [15:8] fill_level,
                                              // [31:16] overflow_count
   output logic [1:0]            rsp_tuser,   // [1:0] status
   input  logic                  csr_wr_en,
   input  logic [SIZE_BITS-1:0]  csr_wr_data
);

   logic                 accept;
   mem_req_type          mem_req;
   result_type           result;
   logic [DATA_BITS-1:0] rd_data;
   logic [DATA_BITS-1:0] data_out;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            status_ff;
   logic                  pop_ok_ff;
   logic [FILL_BITS-1:0]  fill_ff;
   logic [COUNT_BITS-1:0] overflow_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;
   assign rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   brfu_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .opcode      (opcode_type'(req_tuser)),
      .data_in     (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mem_req     (mem_req),
      .result      (result)
   );

   brfu_ram #(
      .DEPTH (MAX_SLOTS),
      .WIDTH (DATA_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= result.status;
         pop_ok_ff <= result.pop_ok;
         fill_ff <= result.fill_level;
         overflow_ff <= result.overflow_count;
      end
   end

   assign data_out = pop_ok_ff ? rd_data : '0;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = status_ff;
   assign rsp_tdata = {overflow_ff, fill_ff, data_out};

`ifndef SYNTHESIS
   a_data_only_on_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != ST_DONE |-> data_out == '0)
      else $error("data returned with a refused or corrupt status");
`endif

endmodule
